// File: rtl/wav_header_parser_top_assert.svh
// ----------------------------------------------------------------------------
// wav_header_parser_top_assert.svh
// Assertion macros used by the WAV header parser RTL.
// ----------------------------------------------------------------------------
`ifndef WAV_HEADER_PARSER_TOP_ASSERT_SVH
`define WAV_HEADER_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define WAVHDR_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define WAVHDR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/wavhdr_pkg.sv
// ----------------------------------------------------------------------------
// wavhdr_pkg
// Types, codes and constants of the WAV header parser.
// ----------------------------------------------------------------------------
package wavhdr_pkg;

   localparam logic [31:0] MIN_LENGTH = 32'd44;
   localparam logic [31:0] RESET_RATE = 32'd16000;
   localparam logic [31:0] TAG_RIFF   = 32'h52494646;
   localparam logic [31:0] TAG_WAVE   = 32'h57415645;
   localparam logic [31:0] TAG_FMT    = 32'h666D7420;
   localparam logic [31:0] TAG_DATA   = 32'h64617461;
   localparam logic [31:0] FMT_MIN_LEN = 32'd16;
   localparam logic [15:0] FMT_PCM    = 16'd1;
   localparam logic [15:0] PCM_BITS   = 16'd16;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_SHORT  = 3'd1;
   localparam logic [2:0] ST_MAGIC  = 3'd2;
   localparam logic [2:0] ST_FORMAT = 3'd3;
   localparam logic [2:0] ST_NODATA = 3'd4;

   typedef enum logic [4:0] {
      PH_IDLE   = 5'b00001,
      PH_MAGIC  = 5'b00010,
      PH_HEADER = 5'b00100,
      PH_FMT    = 5'b01000,
      PH_SKIP   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        start_of_buffer;
      logic [31:0] buffer_length;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] pcm_rate;
      logic [31:0] data_offset;
      logic [30:0] sample_count;
   } rsp_item_type;

   // Byte idx of a big-endian four-character tag, idx 0 first.
   function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = tag[31:24];
         2'd1:    b = tag[23:16];
         2'd2:    b = tag[15:8];
         default: b = tag[7:0];
      endcase
      return b;
   endfunction

endpackage

// File: rtl/wav_header_parser_top.sv
// ----------------------------------------------------------------------------
// wav_header_parser_top
// Streaming RIFF/WAVE header check, one buffer byte per transaction.
// ----------------------------------------------------------------------------
// Feed a WAV buffer one byte per transaction, with start_of_buffer and the
// buffer length on its first byte. The block takes one byte every clock
// cycle, sustained while not stalled: each byte is held in an input
// register and, once the result register is free, a single pass of
// compare and counter logic updates the parse state and, when due, loads
// the result register, which drives the rsp channel. Only a result that
// waits in the result register while rsp_ready is low stalls the input,
// and then only once the input register is full as well. At most one
// verdict comes per buffer; bytes after it, and bytes with no buffer
// started, give no transaction. csr_wr_data sets the default sample rate
// (reset 16000), taken when a buffer starts.
// ----------------------------------------------------------------------------
module wav_header_parser_top (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   // byte stream
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_of_buffer,
   input  logic [31:0] req_buffer_length,
   // verdict
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_pcm_rate,
   output logic [31:0] rsp_data_offset,
   output logic [30:0] rsp_sample_count
);
   import wavhdr_pkg::*;

   req_item_type req_item;
   req_item_type item;
   rsp_item_type res;
   rsp_item_type rsp_item;
   logic         item_valid;
   logic         res_valid;
   logic         out_free;

   assign req_item.data_byte       = req_data_byte;
   assign req_item.start_of_buffer = req_start_of_buffer;
   assign req_item.buffer_length   = req_buffer_length;

   // input register: moves on whenever the result side can take a verdict
   wavhdr_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .out_free   (out_free),
      .item_valid (item_valid),
      .item       (item)
   );

   // parse state machine plus default-rate register
   wavhdr_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item_valid  (item_valid),
      .item        (item),
      .res_valid   (res_valid),
      .res         (res)
   );

   // result register toward the consumer
   wavhdr_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_status       = rsp_item.status;
   assign rsp_pcm_rate     = rsp_item.pcm_rate;
   assign rsp_data_offset  = rsp_item.data_offset;
   assign rsp_sample_count = rsp_item.sample_count;

endmodule

// File: rtl/wavhdr_in_stage.sv
// ----------------------------------------------------------------------------
// wavhdr_in_stage
// Input register of the byte stream with valid/ready flow control.
// ----------------------------------------------------------------------------
module wavhdr_in_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  wavhdr_pkg::req_item_type  req_item,
   input  logic                      out_free,
   output logic                      item_valid,
   output wavhdr_pkg::req_item_type  item
);
   import wavhdr_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff;
   logic         advance;

   assign advance   = valid_ff && out_free;
   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = advance;
   assign item       = item_ff;

endmodule

// File: rtl/wavhdr_parse.sv
// ----------------------------------------------------------------------------
// wavhdr_parse
// Parse state and per-byte next-state logic; emits at most one verdict.
// ----------------------------------------------------------------------------
`include "wav_header_parser_top_assert.svh"

module wavhdr_parse (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [31:0]               csr_wr_data,
   input  logic                      item_valid,
   input  wavhdr_pkg::req_item_type  item,
   output logic                      res_valid,
   output wavhdr_pkg::rsp_item_type  res
);
   import wavhdr_pkg::*;

   logic [31:0] dflt_rate_ff;
   phase_type   phase_ff, phase_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] clen_ff, clen_in;
   logic [33:0] cend_ff, cend_in;
   logic [3:0]  sub_ff, sub_in;
   logic [15:0] fmt_ff, fmt_in;
   logic [15:0] bits_ff, bits_in;
   logic [31:0] rate_ff, rate_in;

   logic [7:0]  b;
   logic        fired;
   logic [31:0] pos_inc;
   logic [31:0] rem;
   logic [31:0] dlen;
   logic [2:0]  off3;

   assign b = item.data_byte;

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      len_in    = len_ff;
      tag_in    = tag_ff;
      clen_in   = clen_ff;
      cend_in   = cend_ff;
      sub_in    = sub_ff;
      fmt_in    = fmt_ff;
      bits_in   = bits_ff;
      rate_in   = rate_ff;
      res_valid = 1'b0;
      res       = '0;
      fired     = 1'b0;
      rem       = '0;
      dlen      = '0;
      off3      = sub_ff[2:0];
      pos_inc   = pos_ff + 32'd1;

      if (item_valid) begin
         if (item.start_of_buffer) begin
            pos_in   = '0;
            len_in   = item.buffer_length;
            phase_in = PH_MAGIC;
            tag_in   = '0;
            clen_in  = '0;
            sub_in   = '0;
            fmt_in   = '0;
            bits_in  = '0;
            rate_in  = dflt_rate_ff;
            if (item.buffer_length < MIN_LENGTH) begin
               phase_in   = PH_IDLE;
               res_valid  = 1'b1;
               res.status = ST_SHORT;
               fired      = 1'b1;
            end
         end
         // position of the byte after this one
         pos_inc = pos_in + 32'd1;

         if (!fired && phase_in != PH_IDLE) begin
            if (phase_in == PH_MAGIC) begin
               if (pos_in[31:2] == 30'd0 && b != tag_byte(TAG_RIFF, pos_in[1:0])) begin
                  fired = 1'b1;
               end else if (pos_in[31:2] == 30'd2 && b != tag_byte(TAG_WAVE, pos_in[1:0])) begin
                  fired = 1'b1;
               end else if (pos_in >= 32'd11) begin
                  phase_in = PH_HEADER;
                  sub_in   = '0;
               end
               if (fired) begin
                  phase_in   = PH_IDLE;
                  res_valid  = 1'b1;
                  res.status = ST_MAGIC;
               end
            end else begin
               // chunk body done: this byte opens the next chunk header
               if ((phase_in == PH_FMT || phase_in == PH_SKIP) && {2'b00, pos_in} >= cend_ff) begin
                  phase_in = PH_HEADER;
                  sub_in   = '0;
               end
               if (phase_in == PH_HEADER) begin
                  off3 = sub_in[2:0];
                  if (off3 == 3'd0) begin
                     tag_in  = '0;
                     clen_in = '0;
                  end
                  if (!off3[2]) begin
                     tag_in = {tag_in[23:0], b};
                  end else begin
                     case (off3[1:0])
                        2'd0:    clen_in[7:0]   = b;
                        2'd1:    clen_in[15:8]  = b;
                        2'd2:    clen_in[23:16] = b;
                        default: clen_in[31:24] = b;
                     endcase
                  end
                  sub_in  = sub_in + 4'd1;
                  cend_in = {2'b00, pos_inc} + {2'b00, clen_in} + {33'd0, clen_in[0]};
                  if (off3 == 3'd7) begin
                     if (tag_in == TAG_FMT && clen_in >= FMT_MIN_LEN) begin
                        phase_in = PH_FMT;
                        sub_in   = '0;
                     end else if (tag_in == TAG_DATA) begin
                        // payload starts right after this byte; clamp to buffer
                        rem       = len_in - pos_inc;
                        dlen      = (clen_in > rem) ? rem : clen_in;
                        phase_in  = PH_IDLE;
                        res_valid = 1'b1;
                        fired     = 1'b1;
                        if (dlen[31:1] == 31'd0) begin
                           res.status = ST_NODATA;
                        end else begin
                           res.status       = ST_OK;
                           res.pcm_rate     = rate_in;
                           res.data_offset  = pos_inc;
                           res.sample_count = dlen[31:1];
                        end
                     end else begin
                        phase_in = PH_SKIP;
                     end
                  end
               end else if (phase_in == PH_FMT) begin
                  case (sub_in)
                     4'd0:    fmt_in = {8'd0, b};
                     4'd1:    fmt_in[15:8] = b;
                     4'd4:    rate_in = {24'd0, b};
                     4'd5:    rate_in[15:8] = b;
                     4'd6:    rate_in[23:16] = b;
                     4'd7:    rate_in[31:24] = b;
                     4'd14:   bits_in = {8'd0, b};
                     4'd15:   bits_in[15:8] = b;
                     default: fmt_in = fmt_in;
                  endcase
                  if (sub_in == 4'd15) begin
                     if (fmt_in != FMT_PCM || bits_in != PCM_BITS) begin
                        phase_in   = PH_IDLE;
                        res_valid  = 1'b1;
                        res.status = ST_FORMAT;
                        fired      = 1'b1;
                     end else begin
                        phase_in = PH_SKIP;
                     end
                  end
                  sub_in = sub_in + 4'd1;
               end
            end

            // last byte of the buffer without a verdict
            if (!fired) begin
               if (pos_inc == len_in) begin
                  phase_in   = PH_IDLE;
                  res_valid  = 1'b1;
                  res.status = ST_NODATA;
               end else begin
                  pos_in = pos_inc;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dflt_rate_ff <= RESET_RATE;
         phase_ff     <= PH_IDLE;
         pos_ff       <= '0;
         len_ff       <= '0;
         tag_ff       <= '0;
         clen_ff      <= '0;
         cend_ff      <= 34'd12;
         sub_ff       <= '0;
         fmt_ff       <= '0;
         bits_ff      <= '0;
         rate_ff      <= RESET_RATE;
      end else begin
         if (csr_wr_en) begin
            dflt_rate_ff <= csr_wr_data;
         end
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         tag_ff   <= tag_in;
         clen_ff  <= clen_in;
         cend_ff  <= cend_in;
         sub_ff   <= sub_in;
         fmt_ff   <= fmt_in;
         bits_ff  <= bits_in;
         rate_ff  <= rate_in;
      end
   end

   `WAVHDR_ASSERT_IMPL(a_fail_fields_zero, res_valid && res.status != ST_OK, res.pcm_rate == 32'd0 && res.data_offset == 32'd0 && res.sample_count == 31'd0, "failed verdict carries data")
   `WAVHDR_ASSERT_IMPL(a_pos_in_buffer, phase_ff != PH_IDLE, pos_ff < len_ff, "byte position past buffer end")
   `WAVHDR_ASSERT_IMPL(a_idle_silent, item_valid && !item.start_of_buffer && phase_ff == PH_IDLE, !res_valid, "verdict while idle")
   `WAVHDR_ASSERT_NEXT(a_verdict_idles, res_valid, phase_ff == PH_IDLE, "parse not idle after verdict")
   `WAVHDR_ASSERT_IMPL(a_ok_nonempty, res_valid && res.status == ST_OK, res.sample_count != 31'd0, "ok verdict with no samples")

endmodule

// File: rtl/wavhdr_out_stage.sv
// ----------------------------------------------------------------------------
// wavhdr_out_stage
// Result register holding one verdict until the consumer takes it.
// ----------------------------------------------------------------------------
module wavhdr_out_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      res_valid,
   input  wavhdr_pkg::rsp_item_type  res,
   output logic                      out_free,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output wavhdr_pkg::rsp_item_type  rsp_item
);
   import wavhdr_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (res_valid) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         item_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

// File: test/wavhdr_verdict_pkg.sv
// ----------------------------------------------------------------------------
// wavhdr_verdict_pkg
// Verdict predictor and scoreboard for the WAV header parser bench.
// ----------------------------------------------------------------------------
package wavhdr_verdict_pkg;
   timeunit 1ns;
   timeprecision 1ps;
   import wavhdr_pkg::*;

   class wav_verdict_board;
      logic [31:0]  default_rate;
      logic [31:0]  byte_pos;
      logic [31:0]  buf_len;
      phase_type    phase;
      logic [31:0]  tag;
      logic [31:0]  clen;
      logic [63:0]  chunk_start;
      logic [15:0]  fmt_tag;
      logic [15:0]  sample_bits;
      logic [31:0]  rate;
      rsp_item_type verdicts_due[$];
      int unsigned  n_parsed;
      int unsigned  n_checked;
      int unsigned  errors;

      function new();
         default_rate = RESET_RATE;
         byte_pos     = '0;
         buf_len      = '0;
         phase        = PH_IDLE;
         tag          = '0;
         clen         = '0;
         chunk_start  = 64'd12;
         fmt_tag      = '0;
         sample_bits  = '0;
         rate         = RESET_RATE;
         n_parsed     = 0;
         n_checked    = 0;
         errors       = 0;
      endfunction

      // Closes the parse; fields other than status only carry data on ok.
      function void give_verdict(input logic [2:0] status, input logic [31:0] r,
                                 input logic [31:0] off, input logic [30:0] cnt);
         rsp_item_type v;
         phase          = PH_IDLE;
         v.status       = status;
         v.pcm_rate     = (status == ST_OK) ? r : '0;
         v.data_offset  = (status == ST_OK) ? off : '0;
         v.sample_count = (status == ST_OK) ? cnt : '0;
         verdicts_due.push_back(v);
      endfunction

      function logic [63:0] chunk_end();
         return chunk_start + 64'd8 + {32'd0, clen} + {63'd0, clen[0]};
      endfunction

      // One accepted byte of the stream.
      function void take_byte(input logic [7:0] b, input logic sob,
                              input logic [31:0] len);
         logic [31:0] pos;
         logic [2:0]  hoff;
         logic [3:0]  foff;
         logic [63:0] doff;
         logic [63:0] dlen;
         if (sob) begin
            byte_pos    = '0;
            buf_len     = len;
            phase       = PH_MAGIC;
            tag         = '0;
            clen        = '0;
            chunk_start = 64'd12;
            fmt_tag     = '0;
            sample_bits = '0;
            rate        = default_rate;
            if (len < MIN_LENGTH) begin
               n_parsed++;
               give_verdict(ST_SHORT, '0, '0, '0);
               return;
            end
         end
         if (phase == PH_IDLE)
            return;
         n_parsed++;
         pos = byte_pos;

         if (phase == PH_MAGIC) begin
            if (pos < 4 && b != 8'(TAG_RIFF >> (24 - 8 * pos[1:0]))) begin
               give_verdict(ST_MAGIC, '0, '0, '0);
               return;
            end
            if (pos >= 8 && pos < 12 && b != 8'(TAG_WAVE >> (24 - 8 * pos[1:0]))) begin
               give_verdict(ST_MAGIC, '0, '0, '0);
               return;
            end
            if (pos >= 11) begin
               phase       = PH_HEADER;
               chunk_start = 64'd12;
            end
         end else begin
            if ((phase == PH_FMT || phase == PH_SKIP) && {32'd0, pos} >= chunk_end()) begin
               phase       = PH_HEADER;
               chunk_start = {32'd0, pos};
            end
            if (phase == PH_HEADER) begin
               hoff = 3'({32'd0, pos} - chunk_start);
               if (hoff == 3'd0) begin
                  tag  = '0;
                  clen = '0;
               end
               if (hoff < 3'd4)
                  tag = {tag[23:0], b};
               else
                  clen = clen | (32'(b) << (8 * (hoff - 3'd4)));
               if (hoff == 3'd7) begin
                  if (tag == TAG_FMT && clen >= FMT_MIN_LEN) begin
                     phase = PH_FMT;
                  end else if (tag == TAG_DATA) begin
                     doff = chunk_start + 64'd8;
                     dlen = {32'd0, clen};
                     if (doff + dlen > {32'd0, buf_len})
                        dlen = {32'd0, buf_len} - doff;
                     if (dlen < 64'd2)
                        give_verdict(ST_NODATA, '0, '0, '0);
                     else
                        give_verdict(ST_OK, rate, doff[31:0], dlen[31:1]);
                     return;
                  end else begin
                     phase = PH_SKIP;
                  end
               end
            end else if (phase == PH_FMT) begin
               foff = 4'({32'd0, pos} - chunk_start - 64'd8);
               if (foff == 4'd0)
                  fmt_tag = {8'd0, b};
               else if (foff == 4'd1)
                  fmt_tag = fmt_tag | {b, 8'd0};
               else if (foff == 4'd4)
                  rate = {24'd0, b};
               else if (foff >= 4'd5 && foff <= 4'd7)
                  rate = rate | (32'(b) << (8 * (foff - 4'd4)));
               else if (foff == 4'd14)
                  sample_bits = {8'd0, b};
               else if (foff == 4'd15) begin
                  sample_bits = sample_bits | {b, 8'd0};
                  if (fmt_tag != FMT_PCM || sample_bits != PCM_BITS) begin
                     give_verdict(ST_FORMAT, '0, '0, '0);
                     return;
                  end
                  phase = PH_SKIP;
               end
            end
         end

         // last byte of the buffer with no verdict yet
         if ({32'd0, pos} + 64'd1 >= {32'd0, buf_len}) begin
            give_verdict(ST_NODATA, '0, '0, '0);
            return;
         end
         byte_pos = pos + 32'd1;
      endfunction

      function void check_verdict(input rsp_item_type got);
         rsp_item_type want;
         n_checked++;
         if (verdicts_due.size() == 0) begin
            errors++;
            $display("%0t: verdict with none pending, expected nothing, actual status %0d",
                     $time, got.status);
            return;
         end
         want = verdicts_due.pop_front();
         if (got.status != want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
         end
         if (got.pcm_rate != want.pcm_rate) begin
            errors++;
            $display("%0t: pcm_rate expected %0h actual %0h",
                     $time, want.pcm_rate, got.pcm_rate);
         end
         if (got.data_offset != want.data_offset) begin
            errors++;
            $display("%0t: data_offset expected %0h actual %0h",
                     $time, want.data_offset, got.data_offset);
         end
         if (got.sample_count != want.sample_count) begin
            errors++;
            $display("%0t: sample_count expected %0h actual %0h",
                     $time, want.sample_count, got.sample_count);
         end
      endfunction

      function void check_drained();
         if (verdicts_due.size() != 0) begin
            errors += verdicts_due.size();
            $display("%0t: %0d verdicts expected but never seen", $time, verdicts_due.size());
         end
      endfunction
   endclass

endpackage

// File: test/tb_wav_header_parser_top.sv
// ----------------------------------------------------------------------------
// tb_wav_header_parser_top
// Self-checking bench for the streaming RIFF/WAVE header parser.
// ----------------------------------------------------------------------------
// Streams WAV buffers byte by byte into the parser and checks every verdict
// against a cycle-free predictor. A directed set covers length limits, magic
// errors, format errors, clamping, odd-length padding, buffer end and
// restarts; then random well-formed and broken buffers follow, with random
// gaps on the byte stream and random back-pressure on the verdict channel.
// The default rate register is rewritten between phases while idle.
// ----------------------------------------------------------------------------
module tb_wav_header_parser_top;
   timeunit 1ns;
   timeprecision 1ps;
   import wavhdr_pkg::*;
   import wavhdr_verdict_pkg::*;

   localparam logic [31:0] TAG_LIST = 32'h4C495354;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_start_of_buffer = 1'b0;
   logic [31:0] req_buffer_length = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_pcm_rate;
   logic [31:0] rsp_data_offset;
   logic [30:0] rsp_sample_count;

   wav_verdict_board board = new();

   logic [7:0]  wav_bytes[$];        // buffer under construction
   bit          quiet = 1'b0;        // no idling on either side
   bit          gaps_on = 1'b1;      // sender gaps for the current buffer
   int unsigned ready_burst = 0;
   int unsigned n_sent = 0;          // bytes accepted by the DUT
   int unsigned magic_probe[4] = '{0, 3, 8, 11};

   wav_header_parser_top u_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_start_of_buffer (req_start_of_buffer),
      .req_buffer_length   (req_buffer_length),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_pcm_rate        (rsp_pcm_rate),
      .rsp_data_offset     (rsp_data_offset),
      .rsp_sample_count    (rsp_sample_count)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #1_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Monitors. Both sample at the rising edge, before any NBA of that step
   // lands, so they see exactly what the DUT saw.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         board.take_byte(req_data_byte, req_start_of_buffer, req_buffer_length);
   end

   always @(posedge clock) begin : verdict_mon
      rsp_item_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.status       = rsp_status;
         got.pcm_rate     = rsp_pcm_rate;
         got.data_offset  = rsp_data_offset;
         got.sample_count = rsp_sample_count;
         board.check_verdict(got);
      end
   end

   // Receiver: random stall bursts between random ready stretches;
   // always ready once the run goes quiet.
   always @(posedge clock) begin
      if (quiet) begin
         rsp_ready <= 1'b1;
      end else if (ready_burst == 0) begin
         if ($urandom_range(0, 2) == 0) begin
            rsp_ready   <= 1'b0;
            ready_burst <= $urandom_range(0, 7);
         end else begin
            rsp_ready   <= 1'b1;
            ready_burst <= $urandom_range(1, 40);
         end
      end else begin
         ready_burst <= ready_burst - 1;
      end
   end

   // ---------------------------------------------------------------------
   // Buffer construction
   // ---------------------------------------------------------------------
   function automatic void put_rand(input int unsigned n);
      repeat (n) wav_bytes.push_back(8'($urandom));
   endfunction

   function automatic void put_le(input logic [31:0] v, input int unsigned nb);
      for (int unsigned i = 0; i < nb; i++)
         wav_bytes.push_back(v[8 * i +: 8]);
   endfunction

   // four-character codes go out first character first
   function automatic void put_tag(input logic [31:0] t);
      for (int i = 3; i >= 0; i--)
         wav_bytes.push_back(t[8 * i +: 8]);
   endfunction

   // "RIFF", random riff size, "WAVE"
   function automatic void put_head();
      put_tag(TAG_RIFF);
      put_rand(4);
      put_tag(TAG_WAVE);
   endfunction

   // generic chunk; body (plus pad on odd length) only when it is short
   function automatic void put_chunk(input logic [31:0] t, input logic [31:0] len);
      put_tag(t);
      put_le(len, 4);
      if (len < 256)
         put_rand(len + len[0]);
   endfunction

   // fmt chunk of len >= 16; channels, byte rate and block align random
   function automatic void put_fmt(input logic [31:0] len, input logic [15:0] ftag,
                                   input logic [31:0] r, input logic [15:0] bps);
      put_tag(TAG_FMT);
      put_le(len, 4);
      put_le(32'(ftag), 2);
      put_rand(2);
      put_le(r, 4);
      put_rand(6);
      put_le(32'(bps), 2);
      if (len > 16)
         put_rand(len - 16 + len[0]);
   endfunction

   function automatic void put_data(input logic [31:0] len, input int unsigned nbody);
      put_tag(TAG_DATA);
      put_le(len, 4);
      put_rand(nbody);
   endfunction

   // canonical 44-byte PCM header plus nbody sample bytes
   function automatic void put_std(input logic [31:0] r, input logic [31:0] dlen,
                                   input int unsigned nbody);
      put_head();
      put_fmt(16, FMT_PCM, r, PCM_BITS);
      put_data(dlen, nbody);
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------
   // One transaction; may idle first. Returns at the edge that accepted it.
   task automatic send_byte(input logic [7:0] b, input logic sob, input logic [31:0] len);
      if (gaps_on && !quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_data_byte       <= b;
      req_start_of_buffer <= sob;
      req_buffer_length   <= len;
      do @(posedge clock); while (!req_ready);
      n_sent++;
   endtask

   // Sends the built buffer (or its first cut bytes when cut is nonzero).
   // Only the first byte carries the start mark and the real length.
   task automatic send_wav(input logic [31:0] blen, input int unsigned cut);
      int unsigned cnt;
      cnt = (cut == 0 || cut > wav_bytes.size()) ? wav_bytes.size() : cut;
      for (int unsigned i = 0; i < cnt; i++)
         send_byte(wav_bytes[i], i == 0, (i == 0) ? blen : 32'($urandom));
      wav_bytes.delete();
   endtask

   // Hold the stream until every predicted verdict is out, then let any
   // byte still in the pipe (one that yields no verdict) settle.
   task automatic wait_for_verdicts();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.verdicts_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_default_rate(input logic [31:0] v);
      wait_for_verdicts();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.default_rate = v;
   endtask

   // Random buffer: mostly well-formed with random chunk mix and content,
   // the rest noise, corrupted bytes or a prefix cut off by a restart.
   task automatic send_random_buffer();
      int unsigned kind;
      int unsigned n;
      int unsigned cut;
      logic [31:0] blen;
      logic [31:0] dlen;
      wav_bytes.delete();
      kind = $urandom_range(0, 19);
      cut  = 0;
      if (kind == 0) begin
         put_rand($urandom_range(1, 60));
         blen = $urandom_range(0, 80);
      end else begin
         put_head();
         repeat ($urandom_range(0, 2))
            put_chunk($urandom_range(0, 1) ? TAG_LIST : 32'($urandom), $urandom_range(0, 9));
         case ($urandom_range(0, 9))
            0: ;                                        // no fmt, default rate
            1: put_chunk(TAG_FMT, $urandom_range(0, 15)); // too short, skipped
            2: put_fmt($urandom_range(16, 23),
                       $urandom_range(0, 1) ? FMT_PCM : 16'($urandom), $urandom,
                       $urandom_range(0, 1) ? PCM_BITS : 16'($urandom));
            default: put_fmt($urandom_range(0, 1) ? 16 : 18, FMT_PCM, $urandom, PCM_BITS);
         endcase
         repeat ($urandom_range(0, 1)) put_chunk(TAG_LIST, $urandom_range(0, 9));
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: dlen = $urandom_range(0, 40);
            6, 7:             dlen = $urandom;
            default:          dlen = $urandom_range(0, 3);
         endcase
         put_data(dlen, $urandom_range(0, 8));
         n = wav_bytes.size();
         case ($urandom_range(0, 9))
            6:       blen = $urandom_range(44, n);      // truncated buffer
            7:       blen = $urandom;
            8:       blen = $urandom_range(0, 43);      // too short
            9:       blen = n + $urandom_range(1, 20);
            default: blen = n;
         endcase
         if (kind == 1)
            wav_bytes[$urandom_range(0, 11)] = 8'($urandom);
         else if (kind == 3 || kind == 4)
            wav_bytes[$urandom_range(0, n - 1)] = 8'($urandom);
         else if (kind == 2)
            cut = $urandom_range(1, n);                 // next buffer restarts
      end
      send_wav(blen, cut);
      // stray bytes: ignored after a verdict, parsed if the buffer runs on
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0, $urandom);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : main_seq
      int unsigned phase_mark;
      logic [31:0] v;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed, reset default rate ---
      // bytes with no buffer started: nothing happens
      send_byte(8'h00, 1'b0, 32'h0000_0000);
      send_byte(8'hFF, 1'b0, 32'hFFFF_FFFF);

      // no fmt chunk; odd LIST length needs its pad byte; data clamped
      put_head();
      put_chunk(TAG_LIST, 17);
      put_data(100, 14);
      send_wav(60, 0);

      // plain PCM
      put_std(44100, 8, 8);
      send_wav(52, 0);

      // 18-byte fmt, rate, data length and buffer length all ones
      put_head();
      put_fmt(18, FMT_PCM, 32'hFFFF_FFFF, PCM_BITS);
      put_data(32'hFFFF_FFFF, 2);
      send_wav(32'hFFFF_FFFF, 0);

      // too short: zero and 43; following bytes are ignored
      put_std(8000, 4, 4);
      send_wav(0, 0);
      put_std(8000, 4, 4);
      send_wav(43, 0);

      // exactly 44 with empty data, one data byte, data clamped to one byte
      put_std(22050, 0, 0);
      send_wav(44, 0);
      put_std(0, 1, 1);
      send_wav(45, 0);
      put_std(22050, 1000, 1);
      send_wav(45, 0);

      // magic mismatch on first and last byte of each magic word
      foreach (magic_probe[i]) begin
         put_std(48000, 4, 4);
         wav_bytes[magic_probe[i]] = wav_bytes[magic_probe[i]] ^ 8'h20;
         send_wav(48, 0);
      end

      // unsupported: float tag, 8-bit samples, all-ones fields
      put_head();
      put_fmt(16, 16'd3, 48000, PCM_BITS);
      put_data(4, 4);
      send_wav(48, 0);
      put_head();
      put_fmt(16, FMT_PCM, 48000, 16'd8);
      put_data(4, 4);
      send_wav(48, 0);
      put_head();
      put_fmt(16, 16'hFFFF, 48000, 16'hFFFF);
      put_data(4, 4);
      send_wav(48, 0);

      // fmt under 16 bytes is skipped and keeps the default rate
      put_head();
      put_chunk(TAG_FMT, 14);
      put_data(6, 6);
      send_wav(48, 0);

      // buffer ends inside a skipped chunk, then inside a fmt body
      put_head();
      put_chunk(TAG_LIST, 30);
      put_data(4, 4);
      send_wav(44, 0);
      put_head();
      put_chunk(TAG_LIST, 4);
      put_fmt(16, FMT_PCM, 44100, PCM_BITS);
      put_data(4, 4);
      send_wav(44, 0);

      // skipped chunk of maximum length runs past the buffer end
      put_head();
      put_chunk(TAG_LIST, 32'hFFFF_FFFF);
      put_rand(40);
      send_wav(60, 0);

      // restart in the middle of a header
      put_std(44100, 8, 8);
      send_wav(52, 20);
      put_std(11025, 6, 6);
      send_wav(50, 0);

      // --- default rate at its extremes, used by buffers without fmt ---
      set_default_rate(32'hFFFF_FFFF);
      put_head();
      put_chunk(TAG_LIST, 16);
      put_data(8, 8);
      send_wav(52, 0);
      set_default_rate(32'h0000_0000);
      put_head();
      put_chunk(TAG_LIST, 16);
      put_data(8, 8);
      send_wav(52, 0);

      // --- random buffers, new default rate every ~250 parsed bytes ---
      phase_mark = board.n_parsed;
      while (n_sent < 1300) begin
         if (n_sent >= 1220)
            quiet = 1'b1;
         if (board.n_parsed - phase_mark >= 250) begin
            case ($urandom_range(0, 3))
               0:       v = 32'h0000_0000;
               1:       v = 32'hFFFF_FFFF;
               default: v = $urandom;
            endcase
            set_default_rate(v);
            phase_mark = board.n_parsed;
         end else if ($urandom_range(0, 11) == 0) begin
            wait_for_verdicts();    // let the result side run dry
         end
         gaps_on = ($urandom_range(0, 3) != 0);
         send_random_buffer();
      end

      // drain and report
      quiet = 1'b1;
      wait_for_verdicts();
      board.check_drained();
      if (board.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/wavhdr_pkg.sv
rtl/wavhdr_in_stage.sv
rtl/wavhdr_parse.sv
rtl/wavhdr_out_stage.sv
rtl/wav_header_parser_top.sv
test/wavhdr_verdict_pkg.sv
test/tb_wav_header_parser_top.sv
